// ===== src/binary_keyvalue_record_validator_defines.svh =====
// Assertion macros for the checker file.
`ifndef BINARY_KEYVALUE_RECORD_VALIDATOR_DEFINES_SVH
`define BINARY_KEYVALUE_RECORD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define BKVRV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bkvrv same-cycle check failed");

// Next-cycle implication, sampled on clk and masked during reset.
`define BKVRV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bkvrv next-cycle check failed");

`endif

// ===== src/bkvrv_pkg.sv =====
package bkvrv_pkg;

    // Input item of one transfer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_byte;
        logic       last;
    } in_t;

    // Result item of one transfer.
    typedef struct packed {
        logic       record_start;
        logic [7:0] record_type;
        logic [5:0] nesting_level;
        logic       record_done;
        logic       done_res;
        logic       accepted;
        logic [3:0] error_code;
    } out_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_RECORDS   = 2'd0;
    localparam logic [1:0] CFG_MAX_DEPTH     = 2'd1;
    localparam logic [1:0] CFG_MAX_DOC_BYTES = 2'd2;

    // Register reset values.
    localparam logic [15:0] MAX_RECORDS_RST   = 16'd50000;
    localparam logic [5:0]  MAX_DEPTH_RST     = 6'd32;
    localparam logic [24:0] MAX_DOC_BYTES_RST = 25'h1000000;

    // Verdict codes.
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_EMPTY       = 4'd1;
    localparam logic [3:0] ERR_TOO_LARGE   = 4'd2;
    localparam logic [3:0] ERR_TOO_MANY    = 4'd3;
    localparam logic [3:0] ERR_TOO_DEEP    = 4'd4;
    localparam logic [3:0] ERR_END_MARKER  = 4'd5;
    localparam logic [3:0] ERR_BAD_TYPE    = 4'd6;
    localparam logic [3:0] ERR_UNTERM_STR  = 4'd7;
    localparam logic [3:0] ERR_TRUNC_VALUE = 4'd8;
    localparam logic [3:0] ERR_UNTERM_OBJ  = 4'd9;
    localparam logic [3:0] ERR_BAD_ROOT    = 4'd10;
    localparam logic [3:0] ERR_TRAILING    = 4'd11;

    // Record type markers.
    localparam logic [7:0] TYPE_OBJECT = 8'h00;
    localparam logic [7:0] TYPE_STRING = 8'h01;
    localparam logic [7:0] TYPE_INT32  = 8'h02;
    localparam logic [7:0] TYPE_FLOAT  = 8'h03;
    localparam logic [7:0] TYPE_PTR    = 8'h04;
    localparam logic [7:0] TYPE_COLOR  = 8'h06;
    localparam logic [7:0] TYPE_UINT64 = 8'h07;
    localparam logic [7:0] TYPE_INT64  = 8'h0a;
    localparam logic [7:0] TYPE_END    = 8'h08;

    // Counter limits and root key length.
    localparam logic [24:0] BYTE_COUNT_TOP = 25'h1FFFFFF;
    localparam logic [16:0] REC_COUNT_TOP  = 17'h1FFFF;
    localparam logic [3:0]  ROOT_LEN       = 4'd9;

    // Characters of the required root key "shortcuts".
    function automatic logic [7:0] root_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h73;
            4'd1:    c = 8'h68;
            4'd2:    c = 8'h6f;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h63;
            4'd6:    c = 8'h75;
            4'd7:    c = 8'h74;
            4'd8:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/binary_keyvalue_record_validator.sv =====
// Results are registered: in the result register, or the skid when stalled.
// Throughput: one byte per cycle while in_stall is low; state updates per byte.
// A two-entry output buffer (result register plus skid) absorbs output stalls.
// Reset (rst_n, asynchronous, active low) clears the parser and the output
// buffer and loads the default limits; no clearing pass is needed.
module binary_keyvalue_record_validator
    import bkvrv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_ROOT,
        PH_KEY,
        PH_STR,
        PH_FIX,
        PH_BODY,
        PH_AFTER,
        PH_TAIL,
        PH_HALT
    } phase_t;

    // Limits.
    logic [15:0] max_records_reg;
    logic [5:0]  max_depth_reg;
    logic [24:0] max_doc_bytes_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [6:0]  open_depth_reg, open_depth_next;
    logic [3:0]  fixed_left_reg, fixed_left_next;
    logic [16:0] record_count_reg, record_count_next;
    logic [24:0] byte_count_reg, byte_count_next;
    logic [7:0]  current_type_reg, current_type_next;
    logic [3:0]  root_key_pos_reg, root_key_pos_next;
    logic        root_key_ok_reg, root_key_ok_next;
    logic [3:0]  first_error_reg, first_error_next;

    // Output buffer.
    logic        out_valid_reg;
    out_t        out_data_reg;
    logic        skid_valid_reg;
    out_t        skid_data_reg;

    out_t        result;
    logic        in_fire;
    logic        out_fire;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    // Parse one byte: next state and the result item.
    always_comb
    begin : step
        logic [7:0]  b;
        logic [3:0]  err;
        logic [3:0]  code;
        logic        do_begin;
        logic        do_value_end;
        logic        do_root_end;
        logic [3:0]  fl;
        logic [7:0]  otype;
        logic        rs;
        logic        rdone;

        b            = in_data.data_byte;
        err          = ERR_NONE;
        code         = ERR_NONE;
        do_begin     = 1'b0;
        do_value_end = 1'b0;
        do_root_end  = 1'b0;
        fl           = fixed_left_reg;
        rs           = 1'b0;
        rdone        = 1'b0;

        phase_next        = phase_reg;
        open_depth_next   = open_depth_reg;
        fixed_left_next   = fixed_left_reg;
        record_count_next = record_count_reg;
        byte_count_next   = byte_count_reg;
        current_type_next = current_type_reg;
        root_key_pos_next = root_key_pos_reg;
        root_key_ok_next  = root_key_ok_reg;
        first_error_next  = first_error_reg;

        if (!in_data.no_byte)
        begin
            if (byte_count_reg != BYTE_COUNT_TOP)
            begin
                byte_count_next = byte_count_reg + 25'd1;
            end

            case (phase_reg)
                PH_ROOT:
                begin
                    rs       = 1'b1;
                    do_begin = 1'b1;
                end
                PH_KEY:
                begin
                    if (b != 8'h00)
                    begin
                        // Match the root key character by character.
                        if (open_depth_reg == 7'd0)
                        begin
                            if (root_key_pos_reg < ROOT_LEN &&
                                b == root_char(root_key_pos_reg))
                            begin
                                root_key_pos_next = root_key_pos_reg + 4'd1;
                            end
                            else
                            begin
                                root_key_ok_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        if (open_depth_reg == 7'd0 && root_key_pos_reg != ROOT_LEN)
                        begin
                            root_key_ok_next = 1'b0;
                        end
                        if (current_type_reg == TYPE_OBJECT)
                        begin
                            open_depth_next = open_depth_reg + 7'd1;
                            phase_next      = PH_BODY;
                        end
                        else if (current_type_reg == TYPE_STRING)
                        begin
                            phase_next = PH_STR;
                        end
                        else
                        begin
                            fixed_left_next = (current_type_reg == TYPE_UINT64 ||
                                               current_type_reg == TYPE_INT64)
                                              ? 4'd8 : 4'd4;
                            phase_next      = PH_FIX;
                        end
                    end
                end
                PH_STR:
                begin
                    if (b == 8'h00)
                    begin
                        rdone        = 1'b1;
                        do_value_end = 1'b1;
                    end
                end
                PH_FIX:
                begin
                    if (fixed_left_reg != 4'd0)
                    begin
                        fl = fixed_left_reg - 4'd1;
                    end
                    fixed_left_next = fl;
                    if (fl == 4'd0)
                    begin
                        rdone        = 1'b1;
                        do_value_end = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (b == TYPE_END)
                    begin
                        // Close the innermost object.
                        rdone = 1'b1;
                        if (open_depth_reg != 7'd0)
                        begin
                            open_depth_next = open_depth_reg - 7'd1;
                        end
                        current_type_next = TYPE_OBJECT;
                        if (open_depth_next == 7'd0)
                        begin
                            do_root_end = 1'b1;
                        end
                    end
                    else
                    begin
                        rs       = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                PH_AFTER:
                begin
                    if (b == TYPE_END)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        err = ERR_TRAILING;
                    end
                end
                PH_TAIL:
                begin
                    err = ERR_TRAILING;
                end
                default:
                begin
                end
            endcase

            // Start of a record: count it and check limits and type.
            if (do_begin)
            begin
                if (record_count_reg != REC_COUNT_TOP)
                begin
                    record_count_next = record_count_reg + 17'd1;
                end
                current_type_next = b;
                if (record_count_next > {1'b0, max_records_reg})
                begin
                    err = ERR_TOO_MANY;
                end
                else if (open_depth_reg > {1'b0, max_depth_reg})
                begin
                    err = ERR_TOO_DEEP;
                end
                else if (b == TYPE_END)
                begin
                    err = ERR_END_MARKER;
                end
                else if (!(b inside {TYPE_OBJECT, TYPE_STRING, TYPE_INT32, TYPE_FLOAT,
                                     TYPE_PTR, TYPE_COLOR, TYPE_UINT64, TYPE_INT64}))
                begin
                    err = ERR_BAD_TYPE;
                end
                else
                begin
                    if (open_depth_reg == 7'd0)
                    begin
                        root_key_pos_next = 4'd0;
                        root_key_ok_next  = (b == TYPE_OBJECT);
                    end
                    phase_next = PH_KEY;
                end
            end

            // End of a string or fixed value.
            if (do_value_end)
            begin
                if (open_depth_reg == 7'd0)
                begin
                    do_root_end = 1'b1;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end

            // The root record is complete.
            if (do_root_end)
            begin
                if (!root_key_ok_reg)
                begin
                    err = ERR_BAD_ROOT;
                end
                else
                begin
                    phase_next = PH_AFTER;
                end
            end

            // Record the first error and stop parsing.
            if (err != ERR_NONE)
            begin
                if (first_error_reg == ERR_NONE)
                begin
                    first_error_next = err;
                end
                phase_next = PH_HALT;
            end
        end

        otype = current_type_next;
        if (rdone)
        begin
            current_type_next = TYPE_OBJECT;
        end

        // Verdict on the last item.
        if (in_data.last)
        begin
            if (byte_count_next == 25'd0)
            begin
                code = ERR_EMPTY;
            end
            else if (byte_count_next > max_doc_bytes_reg ||
                     byte_count_next == BYTE_COUNT_TOP)
            begin
                code = ERR_TOO_LARGE;
            end
            else if (first_error_next != ERR_NONE)
            begin
                code = first_error_next;
            end
            else if (phase_next == PH_KEY || phase_next == PH_STR)
            begin
                code = ERR_UNTERM_STR;
            end
            else if (phase_next == PH_FIX)
            begin
                code = ERR_TRUNC_VALUE;
            end
            else if (phase_next == PH_BODY)
            begin
                code = ERR_UNTERM_OBJ;
            end
            else
            begin
                code = ERR_NONE;
            end
        end

        result.record_start  = rs;
        result.record_type   = otype;
        result.nesting_level = open_depth_next[6] ? 6'd63 : open_depth_next[5:0];
        result.record_done   = rdone;
        result.done_res      = in_data.last;
        result.accepted      = in_data.last && (code == ERR_NONE);
        result.error_code    = code;

        // A finished document returns the parser to its reset state.
        if (in_data.last)
        begin
            phase_next        = PH_ROOT;
            open_depth_next   = 7'd0;
            fixed_left_next   = 4'd0;
            record_count_next = 17'd0;
            byte_count_next   = 25'd0;
            current_type_next = 8'd0;
            root_key_pos_next = 4'd0;
            root_key_ok_next  = 1'b1;
            first_error_next  = ERR_NONE;
        end
    end

    // State, limits and output buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_records_reg   <= MAX_RECORDS_RST;
            max_depth_reg     <= MAX_DEPTH_RST;
            max_doc_bytes_reg <= MAX_DOC_BYTES_RST;
            phase_reg         <= PH_ROOT;
            open_depth_reg    <= 7'd0;
            fixed_left_reg    <= 4'd0;
            record_count_reg  <= 17'd0;
            byte_count_reg    <= 25'd0;
            current_type_reg  <= 8'd0;
            root_key_pos_reg  <= 4'd0;
            root_key_ok_reg   <= 1'b1;
            first_error_reg   <= ERR_NONE;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
            skid_valid_reg    <= 1'b0;
            skid_data_reg     <= '0;
        end
        else
        begin
            // Configuration transfer.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_RECORDS:   max_records_reg   <= cfg_data[15:0];
                    CFG_MAX_DEPTH:     max_depth_reg     <= cfg_data[5:0];
                    CFG_MAX_DOC_BYTES: max_doc_bytes_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // Parser state advances on every input transfer.
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                open_depth_reg   <= open_depth_next;
                fixed_left_reg   <= fixed_left_next;
                record_count_reg <= record_count_next;
                byte_count_reg   <= byte_count_next;
                current_type_reg <= current_type_next;
                root_key_pos_reg <= root_key_pos_next;
                root_key_ok_reg  <= root_key_ok_next;
                first_error_reg  <= first_error_next;
            end

            // Result register with skid stage behind it.
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_data_reg  <= result;
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_data_reg  <= result;
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/bkvrv_checker.sv =====
`include "binary_keyvalue_record_validator_defines.svh"

module bkvrv_checker
    import bkvrv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // A stalled result holds until it is transferred.
    `BKVRV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Input backpressure only while a result is waiting.
    `BKVRV_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)

    // Backpressure starts only after a stalled output cycle.
    `BKVRV_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

    // After every input transfer, out_valid is high in the next cycle.
    `BKVRV_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)

endmodule

bind binary_keyvalue_record_validator bkvrv_checker u_bkvrv_checker (.*);
